/* hw/rtl/ibsv_pkg.sv */
// shared constants for the index bubble sort unit
`default_nettype none

package ibsv_pkg;

   // number of keys one set can hold
   localparam int DEPTH = 64;
   // width of a store index and of the entry count
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   // sort key: signed fixed point, 8 fraction bits
   localparam int KEY_W = 32;
   // result data bus, index padded to whole bytes
   localparam int RSP_DATA_W = ((IDX_W + 7) / 8) * 8;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;

endpackage : ibsv_pkg

`default_nettype wire

/* hw/rtl/ibsv_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module ibsv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ibsv_ram

`default_nettype wire

/* hw/rtl/index_bubble_sort_by_value_unit.sv */
// top level of the index bubble sort unit
`default_nettype none

// Collects signed keys (32 bits, 8 fraction bits) one per request on the
// req_ channel, stored in arrival order, up to 64 of them; further keys are
// dropped. A request with req_tlast high closes the set: the unit bubble-sorts
// the arrival indices ascending by key (equal keys keep arrival order) and then
// sends one rsp_ item per stored key, the arrival index of the entry at each
// rank, with rsp_tlast on the final one.
// Loading takes a new request every clock. The sort runs on one shared
// comparator fed by two rams with registered reads (keys and the index
// order): each compare-swap step fetches the neighbor's key, then compares
// and writes back, and each pass adds states to fetch the head and settle
// the carried maximum; each result is read, loaded and held until taken.
// req_tready is low from the closing request until the final result is taken.
// A stalled receiver holds the current result on rsp_tdata and the unit waits.
// Reset (synchronous, active high) empties the set and drops any sort or
// result in progress; stored keys are not cleared.
module index_bubble_sort_by_value_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [ibsv_pkg::KEY_W-1:0]         req_tdata,  // [31:0] key
   input  wire logic                               req_tlast,  // last_item
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [ibsv_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [5:0] original_index
   output logic                                    rsp_tlast   // last_of_run
);

   import ibsv_pkg::*;

   // sequencer states
   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_P0      = 4'd1;
   localparam logic [3:0] S_P1      = 4'd2;
   localparam logic [3:0] S_P2      = 4'd3;
   localparam logic [3:0] S_RK      = 4'd4;
   localparam logic [3:0] S_CMP     = 4'd5;
   localparam logic [3:0] S_PEND    = 4'd6;
   localparam logic [3:0] S_EMIT_RD = 4'd7;
   localparam logic [3:0] S_EMIT_LD = 4'd8;
   localparam logic [3:0] S_EMIT_WT = 4'd9;

   logic [3:0] state_ff, state_in;
   cnt_type    count_ff, count_in;
   idx_type    lim_ff, lim_in;
   idx_type    j_ff, j_in;
   idx_type    rank_ff, rank_in;
   idx_type    cur_ff, cur_in;
   key_type    curk_ff, curk_in;
   idx_type    b_ff, b_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;
   idx_type    rsp_idx_ff, rsp_idx_in;

   // ram ports
   logic       key_we;
   idx_type    key_waddr;
   key_type    key_wdata;
   idx_type    key_raddr;
   logic [KEY_W-1:0] key_rdata;
   logic       ord_we;
   idx_type    ord_waddr;
   idx_type    ord_wdata;
   idx_type    ord_raddr;
   idx_type    ord_rdata;

   logic       req_acc;
   logic       has_room;
   cnt_type    cnt_new;
   logic       greater;
   idx_type    j_next;
   cnt_type    rank_next;

   ibsv_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   ibsv_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign has_room   = (count_ff < CNT_W'(DEPTH));
   assign cnt_new    = has_room ? (count_ff + 1'b1) : count_ff;
   // shared comparator: carried key strictly above the next one moves on
   assign greater    = (curk_ff > $signed(key_rdata));
   assign j_next     = j_ff + 1'b1;
   assign rank_next  = CNT_W'(rank_ff) + 1'b1;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lim_in       = lim_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      cur_in       = cur_ff;
      curk_in      = curk_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_idx_in   = rsp_idx_ff;
      key_we       = 1'b0;
      key_waddr    = count_ff[IDX_W-1:0];
      key_wdata    = req_tdata;
      key_raddr    = ord_rdata;
      ord_we       = 1'b0;
      ord_waddr    = count_ff[IDX_W-1:0];
      ord_wdata    = count_ff[IDX_W-1:0];
      ord_raddr    = '0;

      case (state_ff)
         // store key and identity index, close set on last
         S_LOAD: begin
            if (req_acc) begin
               key_we   = has_room;
               ord_we   = has_room;
               count_in = cnt_new;
               if (req_tlast) begin
                  lim_in  = IDX_W'(cnt_new - 1'b1);
                  rank_in = '0;
                  if (cnt_new > CNT_W'(1)) begin
                     state_in = S_P0;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         // pass start: fetch head of the order
         S_P0: begin
            ord_raddr = '0;
            j_in      = '0;
            state_in  = S_P1;
         end
         S_P1: begin
            cur_in    = ord_rdata;
            key_raddr = ord_rdata;
            state_in  = S_P2;
         end
         S_P2: begin
            curk_in   = key_rdata;
            ord_raddr = j_next;
            state_in  = S_RK;
         end
         // fetch the neighbor's key
         S_RK: begin
            b_in      = ord_rdata;
            key_raddr = ord_rdata;
            state_in  = S_CMP;
         end
         // compare-swap: write the smaller one back at j, carry the larger
         S_CMP: begin
            ord_we    = 1'b1;
            ord_waddr = j_ff;
            if (greater) begin
               ord_wdata = b_ff;
            end else begin
               ord_wdata = cur_ff;
               cur_in    = b_ff;
               curk_in   = key_rdata;
            end
            j_in      = j_next;
            ord_raddr = j_next + 1'b1;
            if (j_next == lim_ff) begin
               state_in = S_PEND;
            end else begin
               state_in = S_RK;
            end
         end
         // pass end: the carried maximum settles at the pass limit
         S_PEND: begin
            ord_we    = 1'b1;
            ord_waddr = lim_ff;
            ord_wdata = cur_ff;
            lim_in    = lim_ff - 1'b1;
            if (lim_ff == IDX_W'(1)) begin
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_P0;
            end
         end
         // read the index at this rank
         S_EMIT_RD: begin
            ord_raddr = rank_ff;
            state_in  = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_idx_in   = ord_rdata;
            rsp_valid_in = 1'b1;
            rsp_last_in  = (rank_next == count_ff);
            state_in     = S_EMIT_WT;
         end
         // hold the result until taken
         S_EMIT_WT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  rank_in  = rank_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in     = S_LOAD;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lim_ff      <= lim_in;
      j_ff        <= j_in;
      rank_ff     <= rank_in;
      cur_ff      <= cur_in;
      curk_ff     <= curk_in;
      b_ff        <= b_in;
      rsp_last_ff <= rsp_last_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_idx_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule : index_bubble_sort_by_value_unit

`default_nettype wire

/* tb/index_bubble_sort_by_value_unit_tb.sv */
// testbench for the index bubble sort unit: directed and random key sets against a predictor
`timescale 1ns / 100ps

module index_bubble_sort_by_value_unit_tb;
   import ibsv_pkg::*;

   // cycles with no request or result taken before the run is abandoned
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 256;

   // one expected result: arrival index at a sorted rank
   typedef struct packed {
      idx_type index;
      logic    final_rank;
   } rank_entry_type;

   // predictor of the sorted order plus the queue of ranks still owed
   class rank_scoreboard;
      key_type        key_mem [DEPTH];
      int unsigned    stored;
      rank_entry_type owed_q [$];
      int unsigned    errors;
      int unsigned    requests;
      int unsigned    results;
      int unsigned    sets_closed;
      int unsigned    widest_set;

      function new();
         stored = 0;
         errors = 0;
         requests = 0;
         results = 0;
         sets_closed = 0;
         widest_set = 0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      task report(input string what);
         $display("mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      // store the key; on a closing request sort the indices and queue the ranks
      function void note_request(input key_type key, input logic closes);
         idx_type        order [DEPTH];
         idx_type        swap;
         rank_entry_type entry;
         int unsigned    i;
         int unsigned    j;
         requests++;
         if (stored < DEPTH) begin
            key_mem[stored] = key;
            stored++;
         end
         if (!closes) return;
         for (i = 0; i < stored; i++) order[i] = idx_type'(i);
         // only a strictly greater left key swaps, so ties keep arrival order
         for (i = 0; i + 1 < stored; i++) begin
            for (j = 0; j + 1 < stored - i; j++) begin
               if (key_mem[order[j]] > key_mem[order[j+1]]) begin
                  swap = order[j];
                  order[j] = order[j+1];
                  order[j+1] = swap;
               end
            end
         end
         for (i = 0; i < stored; i++) begin
            entry.index = order[i];
            entry.final_rank = (i + 1 == stored);
            owed_q.push_back(entry);
         end
         sets_closed++;
         if (stored > widest_set) widest_set = stored;
         stored = 0;
      endfunction

      // compare one taken result with the oldest owed rank
      task check_result(input logic [RSP_DATA_W-1:0] data, input logic final_flag);
         rank_entry_type entry;
         results++;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected result index %0d last %0b", data, final_flag));
            return;
         end
         entry = owed_q.pop_front();
         if (data !== RSP_DATA_W'(entry.index))
            report($sformatf("index %0d, predicted %0d", data, entry.index));
         if (final_flag !== entry.final_rank)
            report($sformatf("last flag %0b, predicted %0b for index %0d",
                             final_flag, entry.final_rank, entry.index));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [KEY_W-1:0]      req_tdata;   // [31:0] key
   logic                  req_tlast;   // last_item
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [5:0] original_index
   logic                  rsp_tlast;   // last_of_run

   rank_scoreboard sb;
   logic           steady;
   int unsigned    quiet_cycles;

   index_bubble_sort_by_value_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 4 ns period
   always #2 clock = ~clock;

   // receiver with random back-pressure, none during a steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", STALL_LIMIT);
         $display("index_bubble_sort_by_value_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // send one request, with random idle cycles ahead of it outside a steady stretch
   task send_request(input key_type key, input logic closes);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tlast  <= closes;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_request(key, closes);
   endtask

   // key of a given flavor: full range, narrow range with ties, or extremes
   function automatic key_type pick_key(input int flavor);
      key_type k;
      case (flavor)
         1: begin
            k = key_type'($urandom_range(0, 6)) - key_type'(3);
         end
         2: begin
            case ($urandom_range(0, 4))
               0: k = {1'b1, {(KEY_W-1){1'b0}}};
               1: k = {1'b0, {(KEY_W-1){1'b1}}};
               2: k = '0;
               3: k = '1;
               default: k = key_type'($urandom);
            endcase
         end
         default: begin
            k = key_type'($urandom);
         end
      endcase
      return k;
   endfunction

   // send a whole set of random keys, the final one closing it
   task send_set(input int unsigned size, input int flavor);
      int unsigned i;
      for (i = 0; i < size; i++) send_request(pick_key(flavor), i + 1 == size);
   endtask

   initial begin
      int unsigned set_no;
      int unsigned size;
      int unsigned sent;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      steady = 1'b0;
      quiet_cycles = 0;
      sb = new();

      // hold reset, then release it on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single entry set
      send_request(key_type'(0), 1'b1);
      // extremes and fraction-sized steps
      send_request({1'b0, {(KEY_W-1){1'b1}}}, 1'b0);
      send_request({1'b1, {(KEY_W-1){1'b0}}}, 1'b0);
      send_request(key_type'(0), 1'b0);
      send_request(key_type'(-1), 1'b0);
      send_request(key_type'(1), 1'b0);
      send_request({1'b1, {(KEY_W-1){1'b0}}}, 1'b0);
      send_request({1'b0, {(KEY_W-1){1'b1}}}, 1'b0);
      send_request(key_type'(256), 1'b0);
      send_request(key_type'(-256), 1'b1);
      // equal keys keep arrival order
      repeat (3) send_request(key_type'(5), 1'b0);
      send_request(key_type'(5), 1'b1);
      // strictly descending, then strictly ascending
      send_request(key_type'(4), 1'b0);
      send_request(key_type'(3), 1'b0);
      send_request(key_type'(2), 1'b0);
      send_request(key_type'(1), 1'b0);
      send_request(key_type'(0), 1'b1);
      send_request(key_type'(-7), 1'b0);
      send_request(key_type'(0), 1'b0);
      send_request(key_type'(7), 1'b1);

      // random sets: mostly small, a full and an overflowing one
      set_no = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (set_no >= 10 && set_no < 18);
         if (set_no == 2) size = DEPTH + 2 + $urandom_range(0, 2);
         else if (set_no == 9) size = DEPTH;
         else if ($urandom_range(0, 29) == 0) size = $urandom_range(DEPTH / 2, DEPTH);
         else size = $urandom_range(1, 12);
         // sender holds off until every owed rank has come back
         if (set_no == 6) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         send_set(size, $urandom_range(0, 2));
         sent += size;
         set_no++;
      end
      steady = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      // drain the remaining ranks, then a short tail
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d requests in %0d sets, widest set %0d keys, %0d ranks checked",
               sb.requests, sb.sets_closed, sb.widest_set, sb.results);
      $display("sets ran with ties, extreme keys, a full store and dropped keys; %0d errors",
               sb.errors);
      if (sb.errors == 0) begin
         $display("index_bubble_sort_by_value_unit regression: pass");
      end else begin
         $display("index_bubble_sort_by_value_unit regression: fail");
      end
      $finish;
   end

endmodule
